@@ rtl/core/motor_feedback_tracker_assert.svh @@
// assertion macros used by the motor feedback tracker checker
`ifndef MOTOR_FEEDBACK_TRACKER_ASSERT_SVH
`define MOTOR_FEEDBACK_TRACKER_ASSERT_SVH

// same-cycle implication under reset
`define MFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define MFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mft_pkg.sv @@
// shared types, constants and arithmetic helpers of the motor feedback tracker
`default_nettype none
package mft_pkg;

  localparam int MOTORS    = 4;
  localparam int SLOT_W    = $clog2(MOTORS);
  localparam int CNT_W     = 3;
  localparam int ID_W      = 11;
  localparam int OFF_W     = 13;
  localparam int CFG_W     = 52;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_ID0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ID2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ID3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODELS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSETS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VMODE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 3'd7;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [1:0] {
    MODEL_NONE   = 2'd0,
    MODEL_M2006  = 2'd1,
    MODEL_M3508  = 2'd2,
    MODEL_GM6020 = 2'd3
  } model_t;

  typedef enum logic [1:0] {
    KIND_REJECT = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_UPDATE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CALC,
    BK_MUL,
    BK_RND,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic [MOTORS-1:0][ID_W-1:0] feedback_id;
    logic [7:0]                  models;
    logic [CFG_W-1:0]            offsets;
    logic                        voltage_mode;
    logic [CNT_W-1:0]            motor_count;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [15:0]        encoder;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic [7:0]         temp;
  } cmd_t;

  // Q26 scale coefficients, rounded to nearest
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [31:0] ANG_R1    = 32'(PI_Q30);
  localparam logic [31:0] ANG_R36   = 32'((PI_Q30 * 2 + 36) / 72);
  localparam logic [31:0] ANG_R3508 = 32'((PI_Q30 * 187 * 2 + 3591) / 7182);
  localparam logic [39:0] VEL_R1    = 40'((PI_Q30 * 8192 * 2 + 30) / 60);
  localparam logic [39:0] VEL_R36   = 40'((PI_Q30 * 8192 * 2 + 1080) / 2160);
  localparam logic [39:0] VEL_R3508 = 40'((PI_Q30 * 8192 * 187 * 2 + 107730) / 215460);
  localparam logic [39:0] TQ_M2006  = 40'(((64'd18 << 42) * 2 + 100000) / 200000);
  localparam logic [39:0] TQ_M3508  = 40'(64'd6 << 28);
  localparam logic [39:0] TQ_GM_CUR = 40'(((64'd2223 << 28) * 2 + 1000) / 2000);
  localparam logic [39:0] TQ_GM_VOLT = 40'(((64'd2223 << 42) * 2 + 25000000) / 50000000);

  // one wrap of an encoder difference into half a turn
  function automatic logic signed [17:0] wrap_delta(input logic signed [17:0] d);
    logic signed [17:0] r;
    if (d > 18'sd4096) r = d - 18'sd8192;
    else if (d < -18'sd4096) r = d + 18'sd8192;
    else r = d;
    return r;
  endfunction

  // drop 26 fraction bits with half-up rounding on the magnitude, apply sign, saturate
  function automatic logic [31:0] round_q26(input logic [63:0] p, input logic neg);
    logic [63:0] s;
    logic [37:0] r;
    logic [31:0] q;
    s = p + 64'd33554432;
    r = s[63:26];
    if (!neg) q = (r > 38'h7FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
    else q = (r > 38'h80000000) ? 32'h80000000 : (32'd0 - r[31:0]);
    return q;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/mft_if.sv @@
// request and result channels of the motor feedback tracker
`default_nettype none
interface mft_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [10:0] frame_id;
  logic        frame_standard;
  logic [3:0]  frame_length;
  logic [15:0] encoder_raw;
  logic signed [15:0] rotor_speed;
  logic signed [15:0] current_raw;
  logic [7:0]  temperature_raw;

  modport source(output valid, op, frame_id, frame_standard, frame_length, encoder_raw,
                 rotor_speed, current_raw, temperature_raw, input ready);
  modport sink(input valid, op, frame_id, frame_standard, frame_length, encoder_raw,
               rotor_speed, current_raw, temperature_raw, output ready);
endinterface

interface mft_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  motor_index;
  logic [1:0]  result_kind;
  logic [7:0]  temperature_out;
  logic signed [31:0] total_count;
  logic signed [18:0] turns;
  logic signed [31:0] angle_q16;
  logic signed [31:0] velocity_q16;
  logic signed [31:0] torque_q16;
  logic [31:0] frame_tally;
  logic        last;

  modport source(output valid, motor_index, result_kind, temperature_out, total_count,
                 turns, angle_q16, velocity_q16, torque_q16, frame_tally, last,
                 input ready);
  modport sink(input valid, motor_index, result_kind, temperature_out, total_count,
               turns, angle_q16, velocity_q16, torque_q16, frame_tally, last,
               output ready);
endinterface
`default_nettype wire

@@ rtl/core/mft_front.sv @@
// front end: takes requests and matches feedback frames against the slot ids
`default_nettype none
module mft_front (
  mft_in_if.sink         in_ch,
  input  mft_pkg::cfg_t  cfg,
  input  logic           q_full,
  output logic           push,
  output mft_pkg::cmd_t  cmd
);
  import mft_pkg::*;

  logic [CNT_W-1:0]  n;
  logic              ok;
  logic              hit;
  logic [SLOT_W-1:0] slot;

  always_comb begin
    n = (cfg.motor_count > CNT_W'(MOTORS)) ? CNT_W'(MOTORS) : cfg.motor_count;
    ok = in_ch.frame_standard && (in_ch.frame_length >= 4'd7);
    hit = 1'b0;
    slot = '0;
    // walk down so the lowest matching slot wins
    for (int i = MOTORS - 1; i >= 0; i--) begin
      if (ok && (CNT_W'(i) < n) && (cfg.feedback_id[i] == in_ch.frame_id)) begin
        hit = 1'b1;
        slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    cmd.op      = in_ch.op;
    cmd.hit     = hit;
    cmd.slot    = slot;
    cmd.encoder = in_ch.encoder_raw;
    cmd.speed   = in_ch.rotor_speed;
    cmd.current = in_ch.current_raw;
    cmd.temp    = in_ch.temperature_raw;
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

endmodule
`default_nettype wire

@@ rtl/core/mft_queue.sv @@
// short command queue between front and back end
`default_nettype none
module mft_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mft_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output mft_pkg::cmd_t pop_data,
  output logic          empty
);
  import mft_pkg::*;

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign full     = (count_r == (Q_AW + 1)'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (!push && pop) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

@@ rtl/core/mft_back.sv @@
// back end: slot state, frame store, tick walk with shared multiplier, result register
`default_nettype none
module mft_back (
  input  logic          clk,
  input  logic          rst_n,
  input  mft_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  mft_pkg::cmd_t q_data,
  output logic          pop,
  mft_out_if.source     out_ch
);
  import mft_pkg::*;

  bk_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [1:0]       mi_r;
  logic             tick_r;
  logic             out_valid_r;
  logic             load;

  // slot state
  logic [15:0]        enc_now_r    [MOTORS];
  logic signed [15:0] spd_r        [MOTORS];
  logic signed [15:0] cur_r        [MOTORS];
  logic [7:0]         temp_r       [MOTORS];
  logic [31:0]        frames_r     [MOTORS];
  logic [15:0]        enc_before_r [MOTORS];
  logic signed [31:0] total_r      [MOTORS];
  logic [MOTORS-1:0]  online_r;
  logic [MOTORS-1:0]  started_r;

  // result under construction
  logic [SLOT_W-1:0]  res_slot_r;
  kind_t              res_kind_r;
  logic [7:0]         res_temp_r;
  logic signed [31:0] res_total_r;
  logic signed [18:0] res_turn_r;
  logic               turn_en_r;
  logic [31:0]        res_frames_r;
  logic               res_last_r;
  logic signed [31:0] x_r    [3];
  logic [39:0]        coef_r [3];
  logic [31:0]        res_q_r[3];
  logic [63:0]        mul_r;
  logic               neg_r;

  // output register
  logic [SLOT_W-1:0]  o_slot_r;
  kind_t              o_kind_r;
  logic [7:0]         o_temp_r;
  logic signed [31:0] o_total_r;
  logic signed [18:0] o_turn_r;
  logic [31:0]        o_ang_r;
  logic [31:0]        o_vel_r;
  logic [31:0]        o_tq_r;
  logic [31:0]        o_frames_r;
  logic               o_last_r;

  // tick step values
  logic [CNT_W-1:0]   n;
  logic [SLOT_W-1:0]  slot;
  model_t             model;
  logic [OFF_W-1:0]   offset;
  logic signed [17:0] d_gm;
  logic signed [17:0] d_run;
  logic signed [32:0] sum;
  logic signed [31:0] run_total;
  logic signed [31:0] new_total;
  logic [31:0]        acoef;
  logic [39:0]        vcoef;
  logic [39:0]        tcoef;
  logic               later;
  logic signed [31:0] mx;
  logic [31:0]        mag;
  logic [63:0]        prod;
  logic signed [32:0] turn_adj;

  always_comb begin
    n = (cfg.motor_count > CNT_W'(MOTORS)) ? CNT_W'(MOTORS) : cfg.motor_count;
    slot = cnt_r[SLOT_W-1:0];
    model = model_t'(cfg.models[2 * slot +: 2]);
    offset = cfg.offsets[OFF_W * slot +: OFF_W];
    d_gm = wrap_delta($signed({2'b00, enc_now_r[slot]}) - $signed({5'b00000, offset}));
    d_run = wrap_delta($signed({2'b00, enc_now_r[slot]}) - $signed({2'b00, enc_before_r[slot]}));
    sum = 33'(total_r[slot]) + 33'(d_run);
    if (sum[32] != sum[31]) run_total = sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    else run_total = sum[31:0];
    if (model == MODEL_GM6020) new_total = 32'(d_gm);
    else if (!started_r[slot]) new_total = '0;
    else new_total = run_total;
    unique case (model)
      MODEL_M2006: begin
        acoef = ANG_R36;   vcoef = VEL_R36;   tcoef = TQ_M2006;
      end
      MODEL_M3508: begin
        acoef = ANG_R3508; vcoef = VEL_R3508; tcoef = TQ_M3508;
      end
      MODEL_GM6020: begin
        acoef = ANG_R1;    vcoef = VEL_R1;
        tcoef = cfg.voltage_mode ? TQ_GM_VOLT : TQ_GM_CUR;
      end
      default: begin
        acoef = ANG_R1;    vcoef = VEL_R1;    tcoef = '0;
      end
    endcase
    later = 1'b0;
    for (int j = 0; j < MOTORS; j++) begin
      if ((CNT_W'(j) > cnt_r) && (CNT_W'(j) < n) && online_r[j]) later = 1'b1;
    end
  end

  // one multiply per step; angle uses the wide operand, speed and current the narrow one
  always_comb begin
    mx = x_r[mi_r];
    mag = mx[31] ? (32'd0 - mx) : mx;
    if (mi_r == 2'd0) prod = mag * coef_r[0][31:0];
    else prod = 64'(mag[15:0]) * 64'(coef_r[mi_r]);
    turn_adj = res_total_r[31] ? (33'(res_total_r) + 33'sd8191) : 33'(res_total_r);
  end

  always_comb begin
    state_nxt = state_r;
    pop = 1'b0;
    load = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          state_nxt = (q_data.op == OP_TICK) ? BK_CALC : BK_EMIT;
        end
      end
      BK_CALC: begin
        if (cnt_r >= n) state_nxt = BK_IDLE;
        else if (online_r[slot]) state_nxt = BK_MUL;
      end
      BK_MUL: begin
        if (mi_r == 2'd2) state_nxt = BK_RND;
      end
      BK_RND: state_nxt = BK_EMIT;
      BK_EMIT: begin
        load = !out_valid_r || out_ch.ready;
        if (load) state_nxt = tick_r ? BK_CALC : BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      mi_r        <= '0;
      tick_r      <= 1'b0;
      out_valid_r <= 1'b0;
      online_r    <= '0;
      started_r   <= '0;
      for (int i = 0; i < MOTORS; i++) frames_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        BK_IDLE: begin
          if (pop) begin
            tick_r <= (q_data.op == OP_TICK);
            cnt_r  <= '0;
            if (q_data.op == OP_FRAME && q_data.hit) begin
              online_r[q_data.slot] <= 1'b1;
              frames_r[q_data.slot] <= frames_r[q_data.slot] + 32'd1;
            end
          end
        end
        BK_CALC: begin
          mi_r <= '0;
          if (cnt_r < n) begin
            cnt_r <= cnt_r + 1'b1;
            if (online_r[slot]) started_r[slot] <= 1'b1;
          end
        end
        BK_MUL: mi_r <= mi_r + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (pop && q_data.op == OP_FRAME) begin
          res_last_r  <= 1'b1;
          res_total_r <= '0;
          res_turn_r  <= '0;
          for (int k = 0; k < 3; k++) res_q_r[k] <= '0;
          if (q_data.hit) begin
            enc_now_r[q_data.slot] <= q_data.encoder;
            spd_r[q_data.slot]     <= q_data.speed;
            cur_r[q_data.slot]     <= q_data.current;
            temp_r[q_data.slot]    <= q_data.temp;
            res_kind_r   <= KIND_ACCEPT;
            res_slot_r   <= q_data.slot;
            res_temp_r   <= q_data.temp;
            res_frames_r <= frames_r[q_data.slot] + 32'd1;
          end else begin
            res_kind_r   <= KIND_REJECT;
            res_slot_r   <= '0;
            res_temp_r   <= '0;
            res_frames_r <= '0;
          end
        end
      end
      BK_CALC: begin
        if (cnt_r < n && online_r[slot]) begin
          enc_before_r[slot] <= enc_now_r[slot];
          total_r[slot]      <= new_total;
          res_kind_r   <= KIND_UPDATE;
          res_slot_r   <= slot;
          res_temp_r   <= temp_r[slot];
          res_frames_r <= frames_r[slot];
          res_total_r  <= new_total;
          res_last_r   <= !later;
          turn_en_r    <= (model != MODEL_GM6020) && started_r[slot];
          x_r[0]    <= new_total;
          x_r[1]    <= 32'(spd_r[slot]);
          x_r[2]    <= 32'(cur_r[slot]);
          coef_r[0] <= 40'(acoef);
          coef_r[1] <= vcoef;
          coef_r[2] <= tcoef;
        end
      end
      BK_MUL: begin
        mul_r <= prod;
        neg_r <= mx[31];
        if (mi_r != 2'd0) res_q_r[mi_r - 2'd1] <= round_q26(mul_r, neg_r);
        if (mi_r == 2'd0) res_turn_r <= turn_en_r ? turn_adj[31:13] : '0;
      end
      BK_RND: res_q_r[2] <= round_q26(mul_r, neg_r);
      default: ;
    endcase
    if (load) begin
      o_slot_r   <= res_slot_r;
      o_kind_r   <= res_kind_r;
      o_temp_r   <= res_temp_r;
      o_total_r  <= res_total_r;
      o_turn_r   <= res_turn_r;
      o_ang_r    <= res_q_r[0];
      o_vel_r    <= res_q_r[1];
      o_tq_r     <= res_q_r[2];
      o_frames_r <= res_frames_r;
      o_last_r   <= res_last_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.motor_index     = 2'(o_slot_r);
  assign out_ch.result_kind     = o_kind_r;
  assign out_ch.temperature_out = o_temp_r;
  assign out_ch.total_count     = o_total_r;
  assign out_ch.turns           = o_turn_r;
  assign out_ch.angle_q16       = o_ang_r;
  assign out_ch.velocity_q16    = o_vel_r;
  assign out_ch.torque_q16      = o_tq_r;
  assign out_ch.frame_tally     = o_frames_r;
  assign out_ch.last            = o_last_r;

endmodule
`default_nettype wire

@@ rtl/core/motor_feedback_tracker.sv @@
// Tracks feedback of up to four motors: a feedback frame is matched by identifier
// (lowest matching slot wins) and stored, giving one accept or reject result; an
// update tick walks the registered slots and gives one result per online slot with
// the unwrapped or offset-relative count, turn count, and Q16.16 angle, velocity and
// torque at the output shaft. Requests enter a four-deep queue, so the input stays
// ready while the back end works until four requests wait. In the back end a frame
// is popped and then handed off; a tick is popped, then each configured slot gets a
// slot step, and an online slot then makes three passes through the one shared
// multiplier, a rounding step and a hand-off to the output register; a closing slot
// check ends the tick; a stalled result holds the back end in its hand-off step.
// Configuration is written through cfg_we/cfg_index/cfg_wdata and keeps slot state.
`default_nettype none
module motor_feedback_tracker (
  input  logic                           clk,
  input  logic                           rst_n,
  mft_in_if.sink                         in_ch,
  mft_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [mft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mft_pkg::CFG_W-1:0]      cfg_wdata
);
  import mft_pkg::*;

  cfg_t cfg_r;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ID0:     cfg_r.feedback_id[0] <= cfg_wdata[ID_W-1:0];
        CFG_ID1:     cfg_r.feedback_id[1] <= cfg_wdata[ID_W-1:0];
        CFG_ID2:     cfg_r.feedback_id[2] <= cfg_wdata[ID_W-1:0];
        CFG_ID3:     cfg_r.feedback_id[3] <= cfg_wdata[ID_W-1:0];
        CFG_MODELS:  cfg_r.models         <= cfg_wdata[7:0];
        CFG_OFFSETS: cfg_r.offsets        <= cfg_wdata;
        CFG_VMODE:   cfg_r.voltage_mode   <= cfg_wdata[0];
        CFG_COUNT:   cfg_r.motor_count    <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  mft_front u_front (
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  mft_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .empty     (q_empty)
  );

  mft_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_data  (pop_cmd),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

@@ rtl/core/mft_checker.sv @@
// port-level checks of the motor feedback tracker and their binding
`default_nettype none
`include "motor_feedback_tracker_assert.svh"
module mft_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [1:0]  out_index,
  input logic [7:0]  out_temp,
  input logic [31:0] out_total,
  input logic [18:0] out_turn,
  input logic [31:0] out_angle,
  input logic [31:0] out_velocity,
  input logic [31:0] out_torque,
  input logic [31:0] out_update,
  input logic        out_last
);
  import mft_pkg::*;

  `MFT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
    "result dropped while stalled")
  `MFT_ASSERT_IMP(a_frame_last, clk, rst_n, out_valid && out_kind != KIND_UPDATE, out_last,
    "frame result without last")
  `MFT_ASSERT_IMP(a_reject_zero, clk, rst_n, out_valid && out_kind == KIND_REJECT,
    out_index == 2'd0 && out_temp == 8'd0 && out_update == 32'd0,
    "reject result carries slot data")
  `MFT_ASSERT_IMP(a_frame_no_motion, clk, rst_n, out_valid && out_kind != KIND_UPDATE,
    out_total == 32'd0 && out_turn == 19'd0 && out_angle == 32'd0 &&
    out_velocity == 32'd0 && out_torque == 32'd0,
    "frame result carries motion data")

endmodule

bind motor_feedback_tracker mft_checker u_mft_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.result_kind),
  .out_index    (out_ch.motor_index),
  .out_temp     (out_ch.temperature_out),
  .out_total    (out_ch.total_count),
  .out_turn     (out_ch.turns),
  .out_angle    (out_ch.angle_q16),
  .out_velocity (out_ch.velocity_q16),
  .out_torque   (out_ch.torque_q16),
  .out_update   (out_ch.frame_tally),
  .out_last     (out_ch.last)
);
`default_nettype wire
